// ----- rtl/pvt_pkg.sv -----
// Package: shared types, constants and helper functions of the particle vertex transform.
`default_nettype none
package pvt_pkg;

	localparam int DEF_MAX_POINTS   = 64;
	localparam int DEF_CORDIC_STEPS = 16;

	// offset datapath width: holds the exact offset plus CORDIC growth
	localparam int XW = 38;

	localparam logic [23:0]        GAIN_Q24    = 24'd10188014;
	localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
	localparam logic [29:0]        HALF_PI_Q28 = 30'd421657428;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_START = 2'd1,
		MODE_TICK  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_SPIN_RATE     = 3'd0,
		REG_X_VELOCITY    = 3'd1,
		REG_GRAVITY       = 3'd2,
		REG_SCALE_FACTOR  = 3'd3,
		REG_LIFE_TIME     = 3'd4,
		REG_INIT_VY       = 3'd5,
		REG_POINTS_IN_USE = 3'd6
	} reg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE0,
		S_PRE1,
		S_PRE2,
		S_PRE3,
		S_READ,
		S_OFFS,
		S_ROT,
		S_MUL,
		S_FIN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       start;
		logic       tick;
		logic       pre0;
		logic       pre1;
		logic       pre2;
		logic       pre3;
		logic       offs;
		logic       rot;
		logic       mul;
		logic       fin;
		logic [5:0] vidx;
		logic [4:0] step;
		logic [2:0] mul_sel;
	} pvt_cmd_t;

	typedef struct packed {
		logic last;
	} pvt_stat_t;

	function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
		logic signed [31:0] r;
		unique case (i)
			5'd0:    r = 32'sd210828714;
			5'd1:    r = 32'sd124459457;
			5'd2:    r = 32'sd65760959;
			5'd3:    r = 32'sd33381290;
			5'd4:    r = 32'sd16755422;
			5'd5:    r = 32'sd8385879;
			5'd6:    r = 32'sd4193963;
			5'd7:    r = 32'sd2097109;
			5'd8:    r = 32'sd1048571;
			5'd9:    r = 32'sd524287;
			5'd10:   r = 32'sd262144;
			5'd11:   r = 32'sd131072;
			5'd12:   r = 32'sd65536;
			5'd13:   r = 32'sd32768;
			5'd14:   r = 32'sd16384;
			5'd15:   r = 32'sd8192;
			5'd16:   r = 32'sd4096;
			5'd17:   r = 32'sd2048;
			5'd18:   r = 32'sd1024;
			5'd19:   r = 32'sd512;
			5'd20:   r = 32'sd256;
			5'd21:   r = 32'sd128;
			5'd22:   r = 32'sd64;
			5'd23:   r = 32'sd32;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// clamp a 40-bit signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sh007FFFFFFF) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -40'sh0080000000) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/pvt_item_if.sv -----
// Interface: input item channel.
`default_nettype none
interface pvt_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [5:0]         index;
	logic signed [31:0] x;
	logic signed [31:0] y;
	logic [15:0]        dt;

	modport source(output valid, mode, index, x, y, dt, input ready);
	modport sink(input valid, mode, index, x, y, dt, output ready);
endinterface
`default_nettype wire

// ----- rtl/pvt_result_if.sv -----
// Interface: result item channel.
`default_nettype none
interface pvt_result_if;
	logic               valid;
	logic               ready;
	logic [5:0]         vertex_index;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [24:0] life_left;
	logic               last;

	modport source(output valid, vertex_index, out_x, out_y, life_left, last, input ready);
	modport sink(input valid, vertex_index, out_x, out_y, life_left, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/pvt_cfg_if.sv -----
// Interface: configuration write channel.
`default_nettype none
interface pvt_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  reg_index;
	logic [23:0] wdata;

	modport source(output valid, reg_index, wdata, input ready);
	modport sink(input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// ----- rtl/pvt_ctrl.sv -----
// Controller: sequences tick preparation, per-vertex CORDIC, multiplies and output.
`default_nettype none
module pvt_ctrl import pvt_pkg::*; #(
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_mode,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  pvt_stat_t  stat,
	output pvt_cmd_t   cmd
);

	state_t     state_q, state_d;
	logic [5:0] j_q;
	logic [4:0] step_q;
	logic [2:0] mul_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid && in_mode == MODE_TICK) state_d = S_PRE0;
			S_PRE0: state_d = S_PRE1;
			S_PRE1: state_d = S_PRE2;
			S_PRE2: state_d = S_PRE3;
			S_PRE3: state_d = S_READ;
			S_READ: state_d = S_OFFS;
			S_OFFS: state_d = S_ROT;
			S_ROT:  if (step_q == 5'(CORDIC_STEPS - 1)) state_d = S_MUL;
			S_MUL:  if (mul_q == 3'd7) state_d = S_FIN;
			S_FIN:  state_d = S_EMIT;
			S_EMIT: if (out_ready) state_d = stat.last ? S_IDLE : S_READ;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.vidx    = j_q;
		cmd.step    = step_q;
		cmd.mul_sel = mul_q;
		in_ready    = (state_q == S_IDLE);
		out_valid   = (state_q == S_EMIT);
		unique case (state_q)
			S_IDLE: begin
				cmd.load  = in_valid && in_mode == MODE_LOAD;
				cmd.start = in_valid && in_mode == MODE_START;
				cmd.tick  = in_valid && in_mode == MODE_TICK;
			end
			S_PRE0: cmd.pre0 = 1'b1;
			S_PRE1: cmd.pre1 = 1'b1;
			S_PRE2: cmd.pre2 = 1'b1;
			S_PRE3: cmd.pre3 = 1'b1;
			S_OFFS: cmd.offs = 1'b1;
			S_ROT:  cmd.rot  = 1'b1;
			S_MUL:  cmd.mul  = 1'b1;
			S_FIN:  cmd.fin  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q     <= '0;
			step_q  <= '0;
			mul_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_q == S_ROT) ? step_q + 5'd1 : 5'd0;
			mul_q   <= (state_q == S_MUL) ? mul_q + 3'd1 : 3'd0;
			if (state_q == S_IDLE) begin
				j_q <= '0;
			end else if (state_q == S_EMIT && out_ready) begin
				j_q <= j_q + 6'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pvt_dp.sv -----
// Datapath: registers, vertex store, CORDIC rotator and shared multiplier.
`default_nettype none
module pvt_dp import pvt_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pvt_cmd_t           cmd,
	output pvt_stat_t          stat,
	input  logic [5:0]         in_index,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic [15:0]        in_dt,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output logic [5:0]         vertex_index,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [24:0] life_left
);

	localparam int AW = $clog2(MAX_POINTS);

	// configuration registers
	logic [13:0]        spin_q;
	logic signed [10:0] xvel_q;
	logic [15:0]        grav_q;
	logic [15:0]        scale_q;
	logic [23:0]        life_time_q;
	logic signed [15:0] init_vy_q;
	logic [6:0]         pts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_q      <= 14'd0;
			xvel_q      <= 11'sd100;
			grav_q      <= 16'd1000;
			scale_q     <= 16'd32440;
			life_time_q <= 24'd327680;
			init_vy_q   <= 16'sd300;
			pts_q       <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPIN_RATE:     spin_q      <= cfg_data[13:0];
				REG_X_VELOCITY:    xvel_q      <= cfg_data[10:0];
				REG_GRAVITY:       grav_q      <= cfg_data[15:0];
				REG_SCALE_FACTOR:  scale_q     <= cfg_data[15:0];
				REG_LIFE_TIME:     life_time_q <= cfg_data;
				REG_INIT_VY:       init_vy_q   <= cfg_data[15:0];
				REG_POINTS_IN_USE: pts_q       <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// clamped vertex count
	logic [6:0] n_pts;
	always_comb begin
		priority if (pts_q < 7'd2) begin
			n_pts = 7'd2;
		end else if (pts_q > 7'(MAX_POINTS)) begin
			n_pts = 7'(MAX_POINTS);
		end else begin
			n_pts = pts_q;
		end
	end
	assign stat.last = (cmd.vidx == 6'(n_pts - 7'd1));

	// shape state
	logic signed [24:0] life_q;
	logic signed [31:0] vv_q;
	logic signed [31:0] cx_q, cy_q;

	// tick and per-vertex working registers
	logic [15:0]           dt_q;
	logic [31:0]           gdt_q;
	logic signed [27:0]    dx_q;
	logic [29:0]           theta_q;
	logic signed [48:0]    vydt_q;
	logic signed [31:0]    dy_q;
	logic                  flip_q;
	logic signed [31:0]    zt_q, z_q;
	logic signed [XW-1:0]  x_q, y_q;
	logic signed [63:0]    acc_q;
	logic signed [31:0]    ox_q, oy_q;
	logic signed [31:0]    rd_x_q, rd_y_q;

	logic signed [31:0] mem_x [MAX_POINTS];
	logic signed [31:0] mem_y [MAX_POINTS];

	// tick preparation arithmetic
	logic signed [25:0] life_diff;
	logic signed [24:0] life_next;
	logic signed [33:0] vv_diff;
	logic signed [48:0] vydt_rnd;

	assign life_diff = 26'(life_q) - $signed({10'd0, dt_q});
	assign life_next = (life_diff < -26'sd16777216) ? -25'sd16777216 : life_diff[24:0];
	assign vv_diff   = 34'(vv_q) - $signed({2'b00, gdt_q});
	assign vydt_rnd  = vydt_q + 49'sd32768;

	// offset from the centre
	logic signed [XW-1:0] rx, ry;
	assign rx = XW'(rd_x_q) - XW'(cx_q);
	assign ry = XW'(rd_y_q) - XW'(cy_q);

	// CORDIC step
	logic signed [XW-1:0] xs, ys;
	logic signed [31:0]   at;
	assign xs = x_q >>> cmd.step;
	assign ys = y_q >>> cmd.step;
	assign at = atan_q28(cmd.step);

	// shared multiplier: operand split into a low and a high partial product
	logic                 op_y, op_scale, phase_hi;
	logic signed [XW-1:0] mv;
	logic signed [20:0]   mul_a;
	logic signed [24:0]   mul_b;
	logic signed [45:0]   prod;
	logic signed [63:0]   prod64, sum64, shifted;

	assign phase_hi = cmd.mul_sel[0];
	assign op_y     = cmd.mul_sel[1];
	assign op_scale = cmd.mul_sel[2];
	assign mv       = op_y ? y_q : x_q;
	assign mul_a    = phase_hi ? 21'($signed(mv[XW-1:20])) : $signed({1'b0, mv[19:0]});
	assign mul_b    = op_scale ? $signed({9'd0, scale_q}) : $signed({1'b0, GAIN_Q24});
	assign prod     = mul_a * mul_b;
	assign prod64   = prod;
	assign sum64    = acc_q + (prod64 <<< 20)
	                + (op_scale ? (64'sd1 <<< 14) : (64'sd1 <<< 23));
	assign shifted  = op_scale ? (sum64 >>> 15) : (sum64 >>> 24);

	// final placement
	logic signed [31:0] nx, ny;
	assign nx = sat32(40'(cx_q) + 40'(x_q) + 40'(dx_q));
	assign ny = sat32(40'(cy_q) + 40'(y_q) + 40'(dy_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= '0;
			vv_q   <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
		end else begin
			if (cmd.start) begin
				cx_q   <= in_x;
				cy_q   <= in_y;
				vv_q   <= {init_vy_q, 16'd0};
				life_q <= $signed({1'b0, life_time_q});
			end
			if (cmd.pre0) life_q <= life_next;
			if (cmd.pre1) vv_q <= sat32(40'(vv_diff));
			// centre moves once the last vertex has used the old one
			if (cmd.fin && stat.last) begin
				cx_q <= sat32(40'(cx_q) + 40'(dx_q));
				cy_q <= sat32(40'(cy_q) + 40'(dy_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) dt_q <= in_dt;
		if (cmd.pre0) begin
			gdt_q   <= grav_q * dt_q;
			dx_q    <= xvel_q * $signed({1'b0, dt_q});
			theta_q <= dt_q * spin_q;
		end
		if (cmd.pre2) vydt_q <= vv_q * $signed({1'b0, dt_q});
		if (cmd.pre3) begin
			dy_q   <= vydt_rnd[47:16];
			flip_q <= theta_q > HALF_PI_Q28;
			zt_q   <= (theta_q > HALF_PI_Q28) ? $signed({2'b00, theta_q}) - PI_Q28
			                                  : $signed({2'b00, theta_q});
		end
		if (cmd.offs) begin
			x_q <= flip_q ? -rx : rx;
			y_q <= flip_q ? -ry : ry;
			z_q <= zt_q;
		end
		if (cmd.rot) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
		if (cmd.mul) begin
			if (!phase_hi) begin
				acc_q <= prod64;
			end else if (op_y) begin
				y_q <= shifted[XW-1:0];
			end else begin
				x_q <= shifted[XW-1:0];
			end
		end
		if (cmd.fin) begin
			ox_q <= nx;
			oy_q <= ny;
		end
	end

	// vertex store
	always_ff @(posedge clk) begin
		if (cmd.load && ({1'b0, in_index} < 7'(MAX_POINTS))) begin
			mem_x[in_index[AW-1:0]] <= in_x;
			mem_y[in_index[AW-1:0]] <= in_y;
		end else if (cmd.fin) begin
			mem_x[cmd.vidx[AW-1:0]] <= nx;
			mem_y[cmd.vidx[AW-1:0]] <= ny;
		end
		rd_x_q <= mem_x[cmd.vidx[AW-1:0]];
		rd_y_q <= mem_y[cmd.vidx[AW-1:0]];
	end

	assign vertex_index = cmd.vidx;
	assign out_x        = ox_q;
	assign out_y        = oy_q;
	assign life_left    = life_q;

endmodule
`default_nettype wire

// ----- rtl/particle_vertex_transform_core.sv -----
// Top level: particle vertex transform with its channels and checks.
`default_nettype none
// Holds the vertices of one shape. A load transaction stores one vertex, a start
// transaction sets the centre and loads velocity and life, and a tick transaction
// moves the shape by dt: every vertex in use is rotated about the centre by
// CORDIC, scaled, shifted and emitted, the final one flagged last. The length of
// a tick grows with the vertex count, the CORDIC iterations and the eight passes
// through the single shared multiplier for each vertex, and each result is held
// until it is taken. Items are taken one at a time: the input is ready only while
// no tick is in progress. Configuration writes are always accepted and must be
// made while the block is idle.
module particle_vertex_transform_core import pvt_pkg::*; #(
	parameter int MAX_POINTS   = DEF_MAX_POINTS,
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic         clk,
	input  logic         arst_n,
	pvt_item_if.sink     item,
	pvt_result_if.source result,
	pvt_cfg_if.sink      cfg
);

	pvt_cmd_t  cmd;
	pvt_stat_t stat;

	assign cfg.ready = 1'b1;

	pvt_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_mode  (item.mode),
		.in_ready (item.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pvt_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_index    (item.index),
		.in_x        (item.x),
		.in_y        (item.y),
		.in_dt       (item.dt),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.reg_index),
		.cfg_data    (cfg.wdata),
		.vertex_index(result.vertex_index),
		.out_x       (result.out_x),
		.out_y       (result.out_y),
		.life_left   (result.life_left)
	);

	assign result.last = stat.last;

	// no new item while a result is on offer
	a_no_accept_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(item.ready && result.valid))
		else $error("input ready while a result is pending");

	// return to idle after the final vertex of a tick
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.last |=> item.ready)
		else $error("not idle after last vertex");

	// a tick is followed by its results, not by another accept
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.mode == MODE_TICK |=> !item.ready)
		else $error("ready again straight after a tick");

endmodule
`default_nettype wire
